@@ rtl/knnidi_pkg.sv @@
// shared types and constants for the k-nearest-neighbour inverse-distance interpolator
// no dependencies
package knnidi_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_NEIGHBOURS  = 3;
    localparam int CORNERS         = 8;
    localparam int CORNER_IDX_W    = 3;
    localparam int CORNER_W        = 12;
    localparam int POSE_W          = 16;

    // weight given to a sample at distance zero, 1000.0 in Q16
    localparam logic [30:0] ZERO_DIST_WEIGHT = 31'd65536000;

    localparam logic [15:0] X_SCALE_RST   = 16'd7168;
    localparam logic [15:0] Y_SCALE_RST   = 16'd12288;
    localparam logic [15:0] H_SCALE_RST   = 16'd205;
    localparam logic [31:0] CUTOFF_RST    = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] REG_X_SCALE  = 2'd0;
    localparam logic [1:0] REG_Y_SCALE  = 2'd1;
    localparam logic [1:0] REG_H_SCALE  = 2'd2;
    localparam logic [1:0] REG_CUTOFF   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
        logic signed [11:0] bot_left_x;
        logic signed [11:0] bot_left_y;
        logic signed [11:0] bot_right_x;
        logic signed [11:0] bot_right_y;
        logic signed [11:0] top_left_x;
        logic signed [11:0] top_left_y;
        logic signed [11:0] top_right_x;
        logic signed [11:0] top_right_y;
    } in_t;

    typedef struct packed {
        logic signed [11:0] out_bl_x;
        logic signed [11:0] out_bl_y;
        logic signed [11:0] out_br_x;
        logic signed [11:0] out_br_y;
        logic signed [11:0] out_tl_x;
        logic signed [11:0] out_tl_y;
        logic signed [11:0] out_tr_x;
        logic signed [11:0] out_tr_y;
        logic [1:0]         matches_found;
        logic               table_full;
    } out_t;

    // corner 0 is bottom left x, corner 7 top right y
    typedef struct packed {
        logic signed [15:0]                    px;
        logic signed [15:0]                    py;
        logic signed [15:0]                    ph;
        logic [CORNERS-1:0][CORNER_W-1:0]      corner;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WSEL,
        ST_SQRT,
        ST_WGT,
        ST_RECIP,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_DSETUP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

@@ rtl/knn_inverse_distance_interpolator.sv @@
// top level of the k-nearest-neighbour inverse-distance interpolator
// uses knnidi_pkg and knnidi_ram for the sample table
// append and clear give no result; unused op codes are dropped
// query: a pipelined table scan, then per neighbour the root, the reciprocal and the corner
//   products, the reciprocal skipped when its distance is zero, then the per-corner division
// one item in work at a time, input ready only in idle; a result may wait in the output register
// synchronous active-low reset clears count, flag, scales and control; table contents stay

module knn_inverse_distance_interpolator #(
    parameter int TABLE_DEPTH = knnidi_pkg::DEF_TABLE_DEPTH,
    parameter int NEIGHBOURS  = knnidi_pkg::DEF_NEIGHBOURS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  knnidi_pkg::in_t   s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output knnidi_pkg::out_t  m_payload,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int FND_W = $clog2(NEIGHBOURS + 1);
    localparam int NB_W  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int WS_W  = 31 + FND_W;
    localparam int NUM_W = 44 + FND_W;
    localparam int DIV_W = WS_W + 14;
    localparam int SW    = $bits(knnidi_pkg::sample_t);
    localparam int CW    = knnidi_pkg::CORNER_W;
    localparam int KW    = knnidi_pkg::CORNER_IDX_W;

    // configuration
    logic [15:0] x_scale_reg, y_scale_reg, h_scale_reg;
    logic [31:0] cutoff_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_scale_reg <= knnidi_pkg::X_SCALE_RST;
            y_scale_reg <= knnidi_pkg::Y_SCALE_RST;
            h_scale_reg <= knnidi_pkg::H_SCALE_RST;
            cutoff_reg  <= knnidi_pkg::CUTOFF_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                knnidi_pkg::REG_X_SCALE: x_scale_reg <= pwdata[15:0];
                knnidi_pkg::REG_Y_SCALE: y_scale_reg <= pwdata[15:0];
                knnidi_pkg::REG_H_SCALE: h_scale_reg <= pwdata[15:0];
                knnidi_pkg::REG_CUTOFF:  cutoff_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            knnidi_pkg::REG_X_SCALE: prdata = {16'd0, x_scale_reg};
            knnidi_pkg::REG_Y_SCALE: prdata = {16'd0, y_scale_reg};
            knnidi_pkg::REG_H_SCALE: prdata = {16'd0, h_scale_reg};
            knnidi_pkg::REG_CUTOFF:  prdata = cutoff_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    // state
    knnidi_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic signed [15:0] qx_reg, qy_reg, qh_reg;

    logic [31:0]      best_d_reg   [NEIGHBOURS];
    logic [IDX_W-1:0] best_idx_reg [NEIGHBOURS];
    logic [FND_W-1:0] found_reg;
    logic [FND_W-1:0] nb_j_reg;

    logic [31:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [3:0]  sq_cnt_reg;
    logic [16:0] rc_rem_reg;
    logic [30:0] rc_q_reg;
    logic [4:0]  rc_cnt_reg;
    logic [30:0] w_reg;
    logic [WS_W-1:0] wsum_reg;
    logic [KW-1:0]   k_reg;
    logic signed [43:0]      prod_reg;
    logic signed [NUM_W-1:0] num_reg [knnidi_pkg::CORNERS];
    logic [DIV_W-1:0] dv_rem_reg, dv_den_reg;
    logic [11:0]      dv_q_reg;
    logic [3:0]       dv_cnt_reg;
    logic [CW-1:0]    corner_out_reg [knnidi_pkg::CORNERS];

    logic             m_valid_reg;
    knnidi_pkg::out_t m_payload_reg;

    // handshakes
    logic in_acc, do_append, scan_issue, out_load, pipe_busy;
    assign s_ready    = (state_reg == knnidi_pkg::ST_IDLE);
    assign in_acc     = s_valid & s_ready;
    assign do_append  = in_acc && (s_payload.op == knnidi_pkg::OP_APPEND)
                        && (count_reg < CNT_W'(TABLE_DEPTH));
    assign scan_issue = (state_reg == knnidi_pkg::ST_SCAN) && (scan_idx_reg < count_reg);
    assign out_load   = (state_reg == knnidi_pkg::ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;
    assign m_payload  = m_payload_reg;

    // sample table
    knnidi_pkg::sample_t wr_sample, rd_sample;
    logic [SW-1:0]    ram_rdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_re;

    always_comb begin
        wr_sample.px = s_payload.pos_x;
        wr_sample.py = s_payload.pos_y;
        wr_sample.ph = s_payload.heading;
        wr_sample.corner[0] = s_payload.bot_left_x;
        wr_sample.corner[1] = s_payload.bot_left_y;
        wr_sample.corner[2] = s_payload.bot_right_x;
        wr_sample.corner[3] = s_payload.bot_right_y;
        wr_sample.corner[4] = s_payload.top_left_x;
        wr_sample.corner[5] = s_payload.top_left_y;
        wr_sample.corner[6] = s_payload.top_right_x;
        wr_sample.corner[7] = s_payload.top_right_y;
    end

    assign ram_re    = scan_issue || (state_reg == knnidi_pkg::ST_READ);
    assign ram_raddr = (state_reg == knnidi_pkg::ST_SCAN) ? scan_idx_reg[IDX_W-1:0]
                                                          : best_idx_reg[nb_j_reg[NB_W-1:0]];
    assign rd_sample = ram_rdata;

    knnidi_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (do_append),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_sample),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // distance pipeline: read data, scaled differences, squares, saturated sum, insertion
    function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

    logic rd_v_reg, e_v_reg, q_v_reg, d_v_reg;
    logic [IDX_W-1:0] idx_a_reg, idx_b_reg, idx_c_reg, idx_d_reg;
    logic [20:0] ex_reg, ey_reg;
    logic [28:0] eh_reg;
    logic [41:0] sqx_reg, sqy_reg;
    logic [57:0] sqh_reg;
    logic [31:0] d_reg;
    logic        cand_reg;

    logic [32:0] mx, my, mh;
    logic [58:0] d2_sum;

    assign mx     = abs_diff(rd_sample.px, qx_reg) * x_scale_reg;
    assign my     = abs_diff(rd_sample.py, qy_reg) * y_scale_reg;
    assign mh     = abs_diff(rd_sample.ph, qh_reg) * h_scale_reg;
    assign d2_sum = 59'(sqx_reg) + 59'(sqy_reg) + 59'(sqh_reg);
    assign pipe_busy = rd_v_reg | e_v_reg | q_v_reg | d_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            e_v_reg  <= 1'b0;
            q_v_reg  <= 1'b0;
            d_v_reg  <= 1'b0;
        end else begin
            rd_v_reg <= scan_issue;
            e_v_reg  <= rd_v_reg;
            q_v_reg  <= e_v_reg;
            d_v_reg  <= q_v_reg;
        end
        idx_a_reg <= scan_idx_reg[IDX_W-1:0];
        idx_b_reg <= idx_a_reg;
        idx_c_reg <= idx_b_reg;
        idx_d_reg <= idx_c_reg;
        ex_reg    <= mx[32:12];
        ey_reg    <= my[32:12];
        eh_reg    <= mh[32:4];
        sqx_reg   <= ex_reg * ex_reg;
        sqy_reg   <= ey_reg * ey_reg;
        sqh_reg   <= eh_reg * eh_reg;
        d_reg     <= (d2_sum[58:32] != '0) ? 32'hFFFF_FFFF : d2_sum[31:0];
        cand_reg  <= (d2_sum[58:32] == '0) && (d2_sum[31:0] < cutoff_reg);
    end

    // insertion into the sorted neighbour list
    logic [NEIGHBOURS-1:0] ins_at, shift_at;
    logic                  seen, ins_any;
    logic [31:0]           best_d_new   [NEIGHBOURS];
    logic [IDX_W-1:0]      best_idx_new [NEIGHBOURS];

    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < NEIGHBOURS; j++) begin
            shift_at[j] = seen;
            ins_at[j]   = !seen && ((FND_W'(j) >= found_reg) || (d_reg < best_d_reg[j]));
            seen        = seen | ins_at[j];
        end
        ins_any = seen;
        for (int j = 0; j < NEIGHBOURS; j++) begin
            best_d_new[j]   = best_d_reg[j];
            best_idx_new[j] = best_idx_reg[j];
            if (ins_at[j]) begin
                best_d_new[j]   = d_reg;
                best_idx_new[j] = idx_d_reg;
            end
        end
        for (int j = 1; j < NEIGHBOURS; j++) begin
            if (shift_at[j]) begin
                best_d_new[j]   = best_d_reg[j-1];
                best_idx_new[j] = best_idx_reg[j-1];
            end
        end
    end

    // root, reciprocal and division step logic
    logic [31:0] sq_trial;
    logic [16:0] rc_trial;
    logic        rc_ge;
    logic [30:0] rc_q_next;
    logic [DIV_W-1:0] dv_trial;
    logic        dv_ge;
    logic [11:0] dv_q_next;
    logic signed [DIV_W-1:0] dv_n;
    logic signed [43:0] corner_prod;

    assign sq_trial  = sq_res_reg + sq_bit_reg;
    assign rc_trial  = {rc_rem_reg[15:0], (rc_cnt_reg == 5'd0)};
    assign rc_ge     = rc_trial >= {1'b0, sq_res_reg[15:0]};
    assign rc_q_next = {rc_q_reg[29:0], rc_ge};
    assign dv_trial  = dv_den_reg << dv_cnt_reg;
    assign dv_ge     = dv_rem_reg >= dv_trial;
    assign dv_q_next = dv_q_reg | (12'(dv_ge) << dv_cnt_reg);
    assign dv_n      = DIV_W'(num_reg[k_reg])
                       + $signed({{(DIV_W-WS_W-11){1'b0}}, wsum_reg, 11'd0});
    assign corner_prod = $signed(rd_sample.corner[k_reg]) * $signed({1'b0, w_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= knnidi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            knnidi_pkg::ST_IDLE: begin
                if (in_acc && (s_payload.op == knnidi_pkg::OP_QUERY)) begin
                    state_next = knnidi_pkg::ST_SCAN;
                end
            end
            knnidi_pkg::ST_SCAN: begin
                if (!scan_issue && !pipe_busy) begin
                    state_next = knnidi_pkg::ST_WSEL;
                end
            end
            knnidi_pkg::ST_WSEL: begin
                if (nb_j_reg != found_reg) begin
                    state_next = knnidi_pkg::ST_SQRT;
                end else if (found_reg == '0) begin
                    state_next = knnidi_pkg::ST_OUT;
                end else begin
                    state_next = knnidi_pkg::ST_DSETUP;
                end
            end
            knnidi_pkg::ST_SQRT: begin
                if (sq_cnt_reg == 4'd15) begin
                    state_next = knnidi_pkg::ST_WGT;
                end
            end
            knnidi_pkg::ST_WGT: begin
                state_next = (sq_res_reg[15:0] == 16'd0) ? knnidi_pkg::ST_READ
                                                         : knnidi_pkg::ST_RECIP;
            end
            knnidi_pkg::ST_RECIP: begin
                if (rc_cnt_reg == 5'd30) begin
                    state_next = knnidi_pkg::ST_READ;
                end
            end
            knnidi_pkg::ST_READ: state_next = knnidi_pkg::ST_MUL;
            knnidi_pkg::ST_MUL:  state_next = knnidi_pkg::ST_ADD;
            knnidi_pkg::ST_ADD: begin
                state_next = (k_reg == KW'(knnidi_pkg::CORNERS - 1)) ? knnidi_pkg::ST_WSEL
                                                                    : knnidi_pkg::ST_MUL;
            end
            knnidi_pkg::ST_DSETUP: state_next = knnidi_pkg::ST_DIV;
            knnidi_pkg::ST_DIV: begin
                if (dv_cnt_reg == 4'd0) begin
                    state_next = (k_reg == KW'(knnidi_pkg::CORNERS - 1))
                                 ? knnidi_pkg::ST_OUT : knnidi_pkg::ST_DSETUP;
                end
            end
            knnidi_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = knnidi_pkg::ST_IDLE;
                end
            end
            default: state_next = knnidi_pkg::ST_IDLE;
        endcase
    end

    // table bookkeeping and neighbour list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            found_reg   <= '0;
            for (int j = 0; j < NEIGHBOURS; j++) begin
                best_d_reg[j]   <= 32'hFFFF_FFFF;
                best_idx_reg[j] <= '0;
            end
        end else begin
            if (in_acc) begin
                case (s_payload.op)
                    knnidi_pkg::OP_APPEND: begin
                        if (do_append) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    knnidi_pkg::OP_CLEAR: begin
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                    knnidi_pkg::OP_QUERY: begin
                        found_reg <= '0;
                        for (int j = 0; j < NEIGHBOURS; j++) begin
                            best_d_reg[j]   <= 32'hFFFF_FFFF;
                            best_idx_reg[j] <= '0;
                        end
                    end
                    default: ;
                endcase
            end else if (d_v_reg && cand_reg && ins_any) begin
                for (int j = 0; j < NEIGHBOURS; j++) begin
                    best_d_reg[j]   <= best_d_new[j];
                    best_idx_reg[j] <= best_idx_new[j];
                end
                if (found_reg != FND_W'(NEIGHBOURS)) begin
                    found_reg <= found_reg + 1'b1;
                end
            end
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            knnidi_pkg::ST_IDLE: begin
                qx_reg       <= s_payload.pos_x;
                qy_reg       <= s_payload.pos_y;
                qh_reg       <= s_payload.heading;
                scan_idx_reg <= '0;
                nb_j_reg     <= '0;
                wsum_reg     <= '0;
                for (int k = 0; k < knnidi_pkg::CORNERS; k++) begin
                    num_reg[k] <= '0;
                end
            end
            knnidi_pkg::ST_SCAN: begin
                if (scan_issue) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            knnidi_pkg::ST_WSEL: begin
                sq_v_reg   <= best_d_reg[nb_j_reg[NB_W-1:0]];
                sq_res_reg <= '0;
                sq_bit_reg <= 32'h4000_0000;
                sq_cnt_reg <= '0;
                k_reg      <= '0;
                if (found_reg == '0) begin
                    for (int k = 0; k < knnidi_pkg::CORNERS; k++) begin
                        corner_out_reg[k] <= '0;
                    end
                end
            end
            knnidi_pkg::ST_SQRT: begin
                if (sq_v_reg >= sq_trial) begin
                    sq_v_reg   <= sq_v_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            knnidi_pkg::ST_WGT: begin
                w_reg      <= knnidi_pkg::ZERO_DIST_WEIGHT;
                rc_rem_reg <= '0;
                rc_q_reg   <= '0;
                rc_cnt_reg <= '0;
            end
            knnidi_pkg::ST_RECIP: begin
                rc_rem_reg <= rc_ge ? (rc_trial - {1'b0, sq_res_reg[15:0]}) : rc_trial;
                rc_q_reg   <= rc_q_next;
                rc_cnt_reg <= rc_cnt_reg + 1'b1;
                w_reg      <= rc_q_next;
            end
            knnidi_pkg::ST_READ: begin
                wsum_reg <= wsum_reg + WS_W'(w_reg);
            end
            knnidi_pkg::ST_MUL: begin
                prod_reg <= corner_prod;
            end
            knnidi_pkg::ST_ADD: begin
                num_reg[k_reg] <= num_reg[k_reg] + NUM_W'(prod_reg);
                k_reg          <= k_reg + 1'b1;
                if (k_reg == KW'(knnidi_pkg::CORNERS - 1)) begin
                    nb_j_reg <= nb_j_reg + 1'b1;
                end
            end
            knnidi_pkg::ST_DSETUP: begin
                // rounded quotient of (num + 2048 wsum) / wsum, offset removed at the end
                dv_rem_reg <= DIV_W'(dv_n <<< 1) + DIV_W'(wsum_reg);
                dv_den_reg <= DIV_W'({wsum_reg, 1'b0});
                dv_q_reg   <= '0;
                dv_cnt_reg <= 4'd11;
            end
            knnidi_pkg::ST_DIV: begin
                if (dv_ge) begin
                    dv_rem_reg <= dv_rem_reg - dv_trial;
                end
                dv_q_reg   <= dv_q_next;
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == 4'd0) begin
                    corner_out_reg[k_reg] <= dv_q_next ^ 12'h800;
                    k_reg <= k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_payload_reg.out_bl_x      <= corner_out_reg[0];
            m_payload_reg.out_bl_y      <= corner_out_reg[1];
            m_payload_reg.out_br_x      <= corner_out_reg[2];
            m_payload_reg.out_br_y      <= corner_out_reg[3];
            m_payload_reg.out_tl_x      <= corner_out_reg[4];
            m_payload_reg.out_tl_y      <= corner_out_reg[5];
            m_payload_reg.out_tr_x      <= corner_out_reg[6];
            m_payload_reg.out_tr_y      <= corner_out_reg[7];
            m_payload_reg.matches_found <= (int'(found_reg) > 3) ? 2'd3 : 2'(found_reg);
            m_payload_reg.table_full    <= dropped_reg;
        end
    end

endmodule

@@ rtl/knnidi_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module knnidi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ tb/sv/knn_inverse_distance_interpolator_test.sv @@
// testbench for the k-nearest-neighbour inverse-distance interpolator
// depends on knnidi_pkg and knn_inverse_distance_interpolator; predicts each query result
// in its own neighbour search and compares every result field with the block's output
`timescale 1ns / 1ps

module knn_inverse_distance_interpolator_test;

    localparam int DEPTH = knnidi_pkg::DEF_TABLE_DEPTH;
    localparam int NCORN = knnidi_pkg::CORNERS;
    // op code with no meaning, the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    knnidi_pkg::in_t      s_payload;
    logic                 m_valid;
    logic                 m_ready;
    knnidi_pkg::out_t     m_payload;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    knn_inverse_distance_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the block state
    logic signed [15:0] pose_x_tab [DEPTH];
    logic signed [15:0] pose_y_tab [DEPTH];
    logic signed [15:0] pose_h_tab [DEPTH];
    logic signed [11:0] corner_tab [DEPTH][NCORN];
    int unsigned        stored_cnt;
    bit                 dropped;
    logic [15:0]        gain_x, gain_y, gain_h;
    logic [31:0]        cutoff;

    knnidi_pkg::out_t pending_results[$];
    int unsigned mismatch_cnt;
    int unsigned query_cnt, append_cnt, result_cnt, empty_cnt, zero_dist_cnt;
    bit          calm;

    always #2 aclk = ~aclk;

    function automatic longint unsigned abs_diff(logic signed [15:0] a, logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? longint'(-d) : longint'(d);
    endfunction

    function automatic logic [31:0] scaled_sq_dist(int unsigned idx, knnidi_pkg::in_t q);
        longint unsigned ex, ey, eh, d2;
        ex = (abs_diff(pose_x_tab[idx], q.pos_x) * gain_x) >> 12;
        ey = (abs_diff(pose_y_tab[idx], q.pos_y) * gain_y) >> 12;
        eh = (abs_diff(pose_h_tab[idx], q.heading) * gain_h) >> 4;
        d2 = ex * ex + ey * ey + eh * eh;
        return (d2 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d2[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(logic [31:0] val);
        longint unsigned v, res, b;
        v = val;
        res = 0;
        b = 64'd1 << 30;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic knnidi_pkg::out_t interpolate_corners(knnidi_pkg::in_t q);
        logic [31:0]      near_dist [3];
        int unsigned      near_idx [3];
        int unsigned      found;
        logic [31:0]      d;
        longint unsigned  root_d, w, wsum, n, quo;
        longint           num [NCORN];
        logic [11:0]      res [NCORN];
        knnidi_pkg::out_t o;
        found = 0;
        wsum = 0;
        for (int j = 0; j < 3; j++) begin
            near_dist[j] = '1;
            near_idx[j] = 0;
        end
        for (int k = 0; k < NCORN; k++) num[k] = 0;
        for (int unsigned i = 0; i < stored_cnt; i++) begin
            d = scaled_sq_dist(i, q);
            if (d < cutoff) begin
                for (int j = 0; j < 3; j++) begin
                    if (j >= found || d < near_dist[j]) begin
                        for (int k = 2; k > j; k--) begin
                            near_dist[k] = near_dist[k-1];
                            near_idx[k] = near_idx[k-1];
                        end
                        near_dist[j] = d;
                        near_idx[j] = i;
                        if (found < 3) found++;
                        break;
                    end
                end
            end
        end
        for (int j = 0; j < found; j++) begin
            root_d = int_sqrt(near_dist[j]);
            if (root_d == 0) zero_dist_cnt++;
            w = (root_d == 0) ? 64'd65536000 : ((64'd1 << 30) / root_d);
            wsum += w;
            for (int k = 0; k < NCORN; k++)
                num[k] += longint'(corner_tab[near_idx[j]][k]) * longint'(w);
        end
        for (int k = 0; k < NCORN; k++) begin
            res[k] = '0;
            if (found > 0 && wsum > 0) begin
                n = longint'(num[k] + 2048 * longint'(wsum));
                quo = (2 * n + wsum) / (2 * wsum);
                res[k] = 12'(longint'(quo) - 2048);
            end
        end
        o.out_bl_x = res[0]; o.out_bl_y = res[1];
        o.out_br_x = res[2]; o.out_br_y = res[3];
        o.out_tl_x = res[4]; o.out_tl_y = res[5];
        o.out_tr_x = res[6]; o.out_tr_y = res[7];
        o.matches_found = 2'(found);
        o.table_full = dropped;
        return o;
    endfunction

    // state update for one accepted transaction
    task automatic apply_item(knnidi_pkg::in_t it);
        case (it.op)
            knnidi_pkg::OP_APPEND: begin
                if (stored_cnt >= DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    pose_x_tab[stored_cnt] = it.pos_x;
                    pose_y_tab[stored_cnt] = it.pos_y;
                    pose_h_tab[stored_cnt] = it.heading;
                    corner_tab[stored_cnt][0] = it.bot_left_x;
                    corner_tab[stored_cnt][1] = it.bot_left_y;
                    corner_tab[stored_cnt][2] = it.bot_right_x;
                    corner_tab[stored_cnt][3] = it.bot_right_y;
                    corner_tab[stored_cnt][4] = it.top_left_x;
                    corner_tab[stored_cnt][5] = it.top_left_y;
                    corner_tab[stored_cnt][6] = it.top_right_x;
                    corner_tab[stored_cnt][7] = it.top_right_y;
                    stored_cnt++;
                end
                append_cnt++;
            end
            knnidi_pkg::OP_QUERY: begin
                pending_results.insert(pending_results.size(), interpolate_corners(it));
                query_cnt++;
            end
            knnidi_pkg::OP_CLEAR: begin
                stored_cnt = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // called at a rising edge; leaves s_valid high after the handshake
    task automatic send_item(knnidi_pkg::in_t it);
        if (!calm && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        apply_item(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            knnidi_pkg::REG_X_SCALE: gain_x = val[15:0];
            knnidi_pkg::REG_Y_SCALE: gain_y = val[15:0];
            knnidi_pkg::REG_H_SCALE: gain_h = val[15:0];
            default:                 cutoff = val;
        endcase
    endtask

    task automatic set_gains(logic [15:0] gx, logic [15:0] gy, logic [15:0] gh,
                             logic [31:0] cut);
        wait_drained();
        write_reg(knnidi_pkg::REG_X_SCALE, {16'h0, gx});
        write_reg(knnidi_pkg::REG_Y_SCALE, {16'h0, gy});
        write_reg(knnidi_pkg::REG_H_SCALE, {16'h0, gh});
        write_reg(knnidi_pkg::REG_CUTOFF, cut);
    endtask

    function automatic knnidi_pkg::in_t make_item(logic [1:0] op, int x, int y, int h);
        knnidi_pkg::in_t it;
        it = '0;
        it.op = op;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.heading = 16'(h);
        it.bot_left_x = 12'($urandom);  it.bot_left_y = 12'($urandom);
        it.bot_right_x = 12'($urandom); it.bot_right_y = 12'($urandom);
        it.top_left_x = 12'($urandom);  it.top_left_y = 12'($urandom);
        it.top_right_x = 12'($urandom); it.top_right_y = 12'($urandom);
        return it;
    endfunction

    function automatic int rand_heading();
        return int'($urandom_range(46080)) - 23040;
    endfunction

    // query near a stored pose so that neighbours fall under the cutoff
    function automatic knnidi_pkg::in_t near_query();
        int unsigned idx;
        int spread;
        if (stored_cnt == 0)
            return make_item(knnidi_pkg::OP_QUERY, int'($urandom) % 32768,
                             int'($urandom) % 32768, rand_heading());
        idx = $urandom_range(stored_cnt - 1);
        spread = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 2000));
        return make_item(knnidi_pkg::OP_QUERY,
                         int'(pose_x_tab[idx]) + int'($urandom_range(2 * spread)) - spread,
                         int'(pose_y_tab[idx]) + int'($urandom_range(2 * spread)) - spread,
                         int'(pose_h_tab[idx]) + int'($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic knnidi_pkg::in_t rand_append();
        return make_item(knnidi_pkg::OP_APPEND, int'($urandom) % 32768,
                         int'($urandom) % 32768, rand_heading());
    endfunction

    function automatic void check_field(string name, int exp, int act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatch_cnt++;
        end
    endfunction

    // result side: random stalls, compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no query waiting");
                    mismatch_cnt++;
                end else begin
                    knnidi_pkg::out_t e;
                    e = pending_results.pop_front();
                    check_field("out_bl_x", e.out_bl_x, m_payload.out_bl_x);
                    check_field("out_bl_y", e.out_bl_y, m_payload.out_bl_y);
                    check_field("out_br_x", e.out_br_x, m_payload.out_br_x);
                    check_field("out_br_y", e.out_br_y, m_payload.out_br_y);
                    check_field("out_tl_x", e.out_tl_x, m_payload.out_tl_x);
                    check_field("out_tl_y", e.out_tl_y, m_payload.out_tl_y);
                    check_field("out_tr_x", e.out_tr_x, m_payload.out_tr_x);
                    check_field("out_tr_y", e.out_tr_y, m_payload.out_tr_y);
                    check_field("matches_found", e.matches_found, m_payload.matches_found);
                    check_field("table_full", e.table_full, m_payload.table_full);
                    result_cnt++;
                    if (e.matches_found == 0) empty_cnt++;
                end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 35);
    end

    task automatic test_extremes();
        knnidi_pkg::in_t it;
        it = make_item(knnidi_pkg::OP_APPEND, -32768, -32768, -23040);
        it.bot_left_x = -12'sd2048; it.bot_left_y = 12'sd2047;
        it.top_right_x = 12'sd2047; it.top_right_y = -12'sd2048;
        send_item(it);
        it = make_item(knnidi_pkg::OP_APPEND, 32767, 32767, 23040);
        it.bot_left_x = 12'sd2047; it.bot_left_y = -12'sd2048;
        it.bot_right_x = -12'sd2048; it.top_left_y = 12'sd2047;
        send_item(it);
        send_item(make_item(knnidi_pkg::OP_APPEND, 0, 0, 0));
        // exact hit, zero distance
        send_item(make_item(knnidi_pkg::OP_QUERY, -32768, -32768, -23040));
        send_item(make_item(knnidi_pkg::OP_QUERY, 32767, 32767, 23040));
        send_item(make_item(knnidi_pkg::OP_QUERY, 0, 0, 0));
        send_item(make_item(knnidi_pkg::OP_QUERY, 100, -100, 64));
        send_item(make_item(OP_UNUSED, 5, 5, 5));
        send_item(make_item(knnidi_pkg::OP_QUERY, -32768, 32767, 0));
    endtask

    task automatic test_ties();
        send_item(make_item(knnidi_pkg::OP_CLEAR, 0, 0, 0));
        send_item(make_item(knnidi_pkg::OP_QUERY, 1, 2, 3));    // empty table
        repeat (4) send_item(make_item(knnidi_pkg::OP_APPEND, 500, 500, 0));
        send_item(make_item(knnidi_pkg::OP_APPEND, 300, 300, 0));
        send_item(make_item(knnidi_pkg::OP_QUERY, 400, 400, 0));
        send_item(make_item(knnidi_pkg::OP_QUERY, 500, 500, 0));
    endtask

    task automatic test_config_extremes();
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (3) send_item(near_query());
        // saturated distance
        send_item(make_item(knnidi_pkg::OP_QUERY, -32768, 32767, 23040));
        set_gains(16'h0, 16'h0, 16'h0, 32'h1);
        repeat (2) send_item(near_query());
        // nothing passes
        set_gains(knnidi_pkg::X_SCALE_RST, knnidi_pkg::Y_SCALE_RST, knnidi_pkg::H_SCALE_RST,
                  32'h0);
        repeat (2) send_item(near_query());
    endtask

    task automatic test_table_full();
        send_item(make_item(knnidi_pkg::OP_CLEAR, 0, 0, 0));
        calm = 1'b1;
        repeat (DEPTH + 2) send_item(rand_append());
        calm = 1'b0;
        send_item(near_query());
        send_item(make_item(knnidi_pkg::OP_CLEAR, 0, 0, 0));
        send_item(near_query());
    endtask

    task automatic test_random_phase(int unsigned n_items);
        int unsigned r;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i == n_items / 2) calm = 1'b1;
            if (i == n_items / 2 + 40) calm = 1'b0;
            r = $urandom_range(99);
            if (stored_cnt < 4 || r < 35)       send_item(rand_append());
            else if (r < 88)                    send_item(near_query());
            else if (r < 93)                    send_item(make_item(knnidi_pkg::OP_QUERY,
                                                    int'($urandom), int'($urandom),
                                                    rand_heading()));
            else if (r < 96)                    send_item(make_item(OP_UNUSED, int'($urandom),
                                                    int'($urandom), int'($urandom)));
            else                                send_item(make_item(knnidi_pkg::OP_CLEAR,
                                                    0, 0, 0));
            if (i == n_items / 3) begin
                // let the pipe empty before going on
                wait_drained();
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        stored_cnt = 0;
        dropped = 1'b0;
        gain_x = knnidi_pkg::X_SCALE_RST;
        gain_y = knnidi_pkg::Y_SCALE_RST;
        gain_h = knnidi_pkg::H_SCALE_RST;
        cutoff = knnidi_pkg::CUTOFF_RST;
        mismatch_cnt = 0;
        query_cnt = 0; append_cnt = 0; result_cnt = 0; empty_cnt = 0; zero_dist_cnt = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_ties();
        test_config_extremes();
        test_table_full();
        set_gains(16'd4096, 16'd2048, 16'd1000, 32'd400_000_000);
        test_random_phase(30);
        set_gains(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), $urandom);
        test_random_phase(30);
        set_gains(knnidi_pkg::X_SCALE_RST, knnidi_pkg::Y_SCALE_RST, knnidi_pkg::H_SCALE_RST,
                  knnidi_pkg::CUTOFF_RST);
        test_random_phase(70);

        wait_drained();
        repeat (600) @(posedge aclk);
        $display("covered %0d appends, %0d queries, %0d results (%0d with no neighbour)",
                 append_cnt, query_cnt, result_cnt, empty_cnt);
        $display("zero-distance neighbours seen: %0d, table overflow and clear exercised",
                 zero_dist_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
